// ===== rtl/core/hrtm_pkg.sv =====
// ----------------------------------------------------------------------------
// hrtm_pkg
// Types, constants and helper functions shared by the Hamming ratio-test
// matcher modules.
// ----------------------------------------------------------------------------
package hrtm_pkg;

   localparam int DESC_WORD_W = 64;
   localparam int NUM_WORDS   = 4;
   localparam int POS_W       = 12;
   localparam int DIST_W      = 9;
   localparam int RATIO_W     = 5;
   localparam int CSR_IDX_W   = 1;
   localparam int POPC_W      = 7;

   localparam logic [DIST_W-1:0] DIST_NONE = 9'd256;

   localparam logic [RATIO_W-1:0] RATIO_NUM_RESET = 5'd4;
   localparam logic [RATIO_W-1:0] RATIO_DEN_RESET = 5'd5;

   localparam logic [63:0] MASK_M1 = 64'h5555555555555555;
   localparam logic [63:0] MASK_M2 = 64'h3333333333333333;
   localparam logic [63:0] MASK_M4 = 64'h0f0f0f0f0f0f0f0f;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_QUERY = 2'd1,
      REQ_CLEAR = 2'd2
   } hrtm_req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RATIO_NUM = 1'd0,
      CSR_RATIO_DEN = 1'd1
   } hrtm_csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } hrtm_state_type;

   typedef struct packed {
      logic [1:0]             req_type;
      logic [DESC_WORD_W-1:0] desc_word0;
      logic [DESC_WORD_W-1:0] desc_word1;
      logic [DESC_WORD_W-1:0] desc_word2;
      logic [DESC_WORD_W-1:0] desc_word3;
      logic [POS_W-1:0]       pos_col;
      logic [POS_W-1:0]       pos_row;
   } hrtm_req_type;

   typedef struct packed {
      logic              matched;
      logic [POS_W-1:0]  query_col;
      logic [POS_W-1:0]  query_row;
      logic [POS_W-1:0]  ref_col;
      logic [POS_W-1:0]  ref_row;
      logic [DIST_W-1:0] best_distance;
   } hrtm_rsp_type;

   // Running best and second-best state reported by the tracker.
   typedef struct packed {
      logic               have_best;
      logic               have_second;
      logic [DIST_W-1:0]  best;
      logic [DIST_W-1:0]  second;
      logic [2*POS_W-1:0] best_pos;
   } hrtm_track_type;

   // Bit count of one 64-bit word: pairwise folding, then a sum of the bytes.
   function automatic logic [POPC_W-1:0] popcount64(input logic [63:0] v);
      logic [63:0]       s1;
      logic [63:0]       s2;
      logic [63:0]       s3;
      logic [POPC_W-1:0] acc;
      s1  = v - ((v >> 1) & MASK_M1);
      s2  = (s1 & MASK_M2) + ((s1 >> 2) & MASK_M2);
      s3  = (s2 + (s2 >> 4)) & MASK_M4;
      acc = '0;
      for (int i = 0; i < 8; i++) begin
         acc = acc + {3'b000, s3[8*i +: 4]};
      end
      return acc;
   endfunction

endpackage

// ===== rtl/core/hrtm_ram.sv =====
// ----------------------------------------------------------------------------
// hrtm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hrtm_ram #(
   parameter int DATA_W = 64,
   parameter int DEPTH  = 1024
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [DATA_W-1:0]                          wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [DATA_W-1:0]                          rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/hrtm_cell.sv =====
// ----------------------------------------------------------------------------
// hrtm_cell
// One cell of the distance chain. It holds one 64-bit word of the query and
// the matching word of every reference entry, and adds its share of the
// Hamming distance to the partial sum handed on from its left neighbor.
// ----------------------------------------------------------------------------
module hrtm_cell import hrtm_pkg::*; #(
   parameter int REF_DEPTH = 1024
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           q_load,
   input  logic [DESC_WORD_W-1:0]                         q_word,
   input  logic                                           wr_en,
   input  logic [((REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1)-1:0] wr_addr,
   input  logic [DESC_WORD_W-1:0]                         wr_data,
   input  logic                                           in_valid,
   input  logic [((REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1)-1:0] in_addr,
   input  logic [DIST_W-1:0]                              in_dist,
   output logic                                           out_valid,
   output logic [((REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1)-1:0] out_addr,
   output logic [DIST_W-1:0]                              out_dist
);

   localparam int ADDR_W = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;

   logic [DESC_WORD_W-1:0] query_ff;
   logic [DESC_WORD_W-1:0] rd_data;
   logic                   s1_valid_ff;
   logic [ADDR_W-1:0]      s1_addr_ff;
   logic [DIST_W-1:0]      s1_dist_ff;
   logic                   out_valid_ff;
   logic [ADDR_W-1:0]      out_addr_ff;
   logic [DIST_W-1:0]      out_dist_ff;
   logic [DIST_W-1:0]      out_dist_in;

   hrtm_ram #(
      .DATA_W (DESC_WORD_W),
      .DEPTH  (REF_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (in_valid),
      .rd_addr (in_addr),
      .rd_data (rd_data)
   );

   assign out_dist_in = s1_dist_ff + DIST_W'(popcount64(query_ff ^ rd_data));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= in_valid;
         out_valid_ff <= s1_valid_ff;
      end
      if (q_load) begin
         query_ff <= q_word;
      end
      s1_addr_ff  <= in_addr;
      s1_dist_ff  <= in_dist;
      out_addr_ff <= s1_addr_ff;
      out_dist_ff <= out_dist_in;
   end

   assign out_valid = out_valid_ff;
   assign out_addr  = out_addr_ff;
   assign out_dist  = out_dist_ff;

endmodule

// ===== rtl/core/hrtm_tracker.sv =====
// ----------------------------------------------------------------------------
// hrtm_tracker
// End of the chain: looks up the position of each scored entry and keeps the
// best and second-best distance of the running query.
// ----------------------------------------------------------------------------
module hrtm_tracker import hrtm_pkg::*; #(
   parameter int REF_DEPTH = 1024
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           start,
   input  logic                                           wr_en,
   input  logic [((REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1)-1:0] wr_addr,
   input  logic [2*POS_W-1:0]                             wr_pos,
   input  logic                                           in_valid,
   input  logic [((REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1)-1:0] in_addr,
   input  logic [DIST_W-1:0]                              in_dist,
   output hrtm_track_type                                 track,
   output logic [$clog2(REF_DEPTH + 1)-1:0]               recv_cnt
);

   localparam int CNT_W = $clog2(REF_DEPTH + 1);

   logic [2*POS_W-1:0] rd_pos;
   logic               s1_valid_ff;
   logic [DIST_W-1:0]  s1_dist_ff;
   hrtm_track_type     track_ff;
   hrtm_track_type     track_in;
   logic [CNT_W-1:0]   recv_ff;
   logic [CNT_W-1:0]   recv_in;

   hrtm_ram #(
      .DATA_W (2*POS_W),
      .DEPTH  (REF_DEPTH)
   ) u_pos_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_pos),
      .rd_en   (in_valid),
      .rd_addr (in_addr),
      .rd_data (rd_pos)
   );

   // Strict compares keep the earlier entry as best on equal distances.
   always_comb begin
      track_in = track_ff;
      recv_in  = recv_ff;
      if (start) begin
         track_in.have_best   = 1'b0;
         track_in.have_second = 1'b0;
         track_in.best        = DIST_NONE;
         track_in.second      = '0;
         track_in.best_pos    = '0;
         recv_in              = '0;
      end else if (s1_valid_ff) begin
         recv_in = recv_ff + CNT_W'(1);
         if (!track_ff.have_best) begin
            track_in.have_best = 1'b1;
            track_in.best      = s1_dist_ff;
            track_in.best_pos  = rd_pos;
         end else if (s1_dist_ff < track_ff.best) begin
            track_in.have_second = 1'b1;
            track_in.second      = track_ff.best;
            track_in.best        = s1_dist_ff;
            track_in.best_pos    = rd_pos;
         end else if (!track_ff.have_second || s1_dist_ff < track_ff.second) begin
            track_in.have_second = 1'b1;
            track_in.second      = s1_dist_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff          <= 1'b0;
         recv_ff              <= '0;
         track_ff.have_best   <= 1'b0;
         track_ff.have_second <= 1'b0;
      end else begin
         s1_valid_ff          <= in_valid;
         recv_ff              <= recv_in;
         track_ff.have_best   <= track_in.have_best;
         track_ff.have_second <= track_in.have_second;
      end
      s1_dist_ff        <= in_dist;
      track_ff.best     <= track_in.best;
      track_ff.second   <= track_in.second;
      track_ff.best_pos <= track_in.best_pos;
   end

   assign track    = track_ff;
   assign recv_cnt = recv_ff;

endmodule

// ===== rtl/core/hamming_ratio_test_matcher_top.sv =====
// ----------------------------------------------------------------------------
// hamming_ratio_test_matcher_top
// Brute-force Hamming matcher with a ratio test over a table of reference
// 256-bit descriptors.
// ----------------------------------------------------------------------------
// Load and clear items leave the controller idle and may follow back to back.
// A query stalls the input while it scans and until its result is written
// to the output register. One entry enters the four-cell chain per cycle;
// each cell registers its RAM read word and then the new partial sum, and a
// receiver that still holds the previous result delays the done state.
// Reset is synchronous and empties the table; the entry memories are not cleared.
// ----------------------------------------------------------------------------
module hamming_ratio_test_matcher_top import hrtm_pkg::*; #(
   parameter int REF_DEPTH = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  hrtm_req_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output hrtm_rsp_type         rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [RATIO_W-1:0]   csr_wr_data
);

   localparam int ADDR_W = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
   localparam int CNT_W  = $clog2(REF_DEPTH + 1);
   localparam int PROD_W = DIST_W + RATIO_W;

   // Controller state.
   hrtm_state_type     state_ff;
   hrtm_state_type     state_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [CNT_W-1:0]   issue_ff;
   logic [CNT_W-1:0]   issue_in;
   logic               issue_valid;
   logic               start;
   logic               accept;
   logic               table_wr;
   logic [POS_W-1:0]   qcol_ff;
   logic [POS_W-1:0]   qrow_ff;

   // Output register.
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   hrtm_rsp_type       rsp_data_ff;
   hrtm_rsp_type       rsp_data_in;
   hrtm_rsp_type       result;

   // Configuration registers.
   logic [RATIO_W-1:0] ratio_num_ff;
   logic [RATIO_W-1:0] ratio_den_ff;

   // Distance chain links: link 0 is fed by the address sequencer, link
   // NUM_WORDS leaves the last cell and goes to the tracker.
   logic                   link_valid [NUM_WORDS+1];
   logic [ADDR_W-1:0]      link_addr  [NUM_WORDS+1];
   logic [DIST_W-1:0]      link_dist  [NUM_WORDS+1];
   logic [DESC_WORD_W-1:0] desc_words [NUM_WORDS];

   hrtm_track_type         track;
   logic [CNT_W-1:0]       recv_cnt;
   logic [PROD_W-1:0]      lhs_prod;
   logic [PROD_W-1:0]      rhs_prod;

   // The block works on one query at a time; while it scans, or holds a
   // finished result that has not yet reached the output register, it
   // stalls the request side. Loads and clears never leave the idle state.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // A load writes every memory slice at the current fill position. A load
   // into a full table is dropped.
   assign table_wr  = accept && (req_data.req_type == REQ_LOAD) &&
                      (count_ff < CNT_W'(REF_DEPTH));

   assign desc_words[0] = req_data.desc_word0;
   assign desc_words[1] = req_data.desc_word1;
   assign desc_words[2] = req_data.desc_word2;
   assign desc_words[3] = req_data.desc_word3;

   assign link_valid[0] = issue_valid;
   assign link_addr[0]  = issue_ff[ADDR_W-1:0];
   assign link_dist[0]  = '0;

   // Each cell reads its own word slice at the address that travels along
   // the chain with the partial sum, so the four reads of one entry line up
   // without any extra alignment registers.
   for (genvar k = 0; k < NUM_WORDS; k++) begin : g_cell
      hrtm_cell #(
         .REF_DEPTH (REF_DEPTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .q_load    (start),
         .q_word    (desc_words[k]),
         .wr_en     (table_wr),
         .wr_addr   (count_ff[ADDR_W-1:0]),
         .wr_data   (desc_words[k]),
         .in_valid  (link_valid[k]),
         .in_addr   (link_addr[k]),
         .in_dist   (link_dist[k]),
         .out_valid (link_valid[k+1]),
         .out_addr  (link_addr[k+1]),
         .out_dist  (link_dist[k+1])
      );
   end

   hrtm_tracker #(
      .REF_DEPTH (REF_DEPTH)
   ) u_tracker (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .wr_en    (table_wr),
      .wr_addr  (count_ff[ADDR_W-1:0]),
      .wr_pos   ({req_data.pos_row, req_data.pos_col}),
      .in_valid (link_valid[NUM_WORDS]),
      .in_addr  (link_addr[NUM_WORDS]),
      .in_dist  (link_dist[NUM_WORDS]),
      .track    (track),
      .recv_cnt (recv_cnt)
   );

   // Ratio test. A query with only one stored entry, or with a second-best
   // distance of zero, always matches; an empty table never does.
   assign lhs_prod = PROD_W'(track.best) * PROD_W'(ratio_den_ff);
   assign rhs_prod = PROD_W'(ratio_num_ff) * PROD_W'(track.second);

   always_comb begin
      result.query_col     = qcol_ff;
      result.query_row     = qrow_ff;
      result.ref_col       = track.best_pos[POS_W-1:0];
      result.ref_row       = track.best_pos[2*POS_W-1:POS_W];
      result.best_distance = track.best;
      if (!track.have_best) begin
         result.matched = 1'b0;
      end else if (!track.have_second || (track.second == '0)) begin
         result.matched = 1'b1;
      end else begin
         result.matched = (lhs_prod < rhs_prod);
      end
   end

   // Sequencer: issues one table address per cycle during the scan and
   // moves on once the tracker has seen every entry.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      issue_valid  = 1'b0;
      start        = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.req_type)
                  REQ_LOAD: begin
                     if (count_ff < CNT_W'(REF_DEPTH)) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  REQ_QUERY: begin
                     start    = 1'b1;
                     issue_in = '0;
                     state_in = ST_SCAN;
                  end
                  REQ_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue_ff < count_ff) begin
               issue_valid = 1'b1;
               issue_in    = issue_ff + CNT_W'(1);
            end
            if (recv_cnt == count_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (start) begin
         qcol_ff <= req_data.pos_col;
         qrow_ff <= req_data.pos_row;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_num_ff <= RATIO_NUM_RESET;
         ratio_den_ff <= RATIO_DEN_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RATIO_NUM: ratio_num_ff <= csr_wr_data;
            CSR_RATIO_DEN: ratio_den_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The fill count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(REF_DEPTH))
      else $error("table fill count exceeds depth");

   // The tracker cannot have seen more entries than were issued.
   a_recv_le_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (recv_cnt <= issue_ff))
      else $error("tracker received more entries than issued");

   // The table does not change while a query walks it.
   a_table_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> $stable(count_ff))
      else $error("table fill count changed during a scan");

   // A result appears only when a query has finished.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");

endmodule
